// ===== src/ics_pkg.sv =====
package ics_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int CNT_BITS = 16;
	localparam int CH_BITS = 3;
	localparam int US_BITS = 32;
	localparam int TS_W = 3;
	localparam int MAXP_W = 20;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int IN_W = 136;
	localparam int OUT_W = 56;
	localparam int ALPHA = 30;
	localparam int ONE_MINUS_ALPHA = 256 - ALPHA;
	localparam int SM_W = 41;

	localparam logic [TS_W-1:0] TS_RST = 3'd2;
	localparam logic [MAXP_W-1:0] MAXP_RST = 20'd262140;

	localparam logic REG_TICK_SHIFT = 1'b0;
	localparam logic REG_MAX_PERIOD = 1'b1;

	typedef enum logic [2:0] {
		CMD_SET = 3'd0,
		CMD_REFRESH = 3'd1,
		CMD_DEC_END = 3'd2,
		CMD_FIRE = 3'd3,
		CMD_DISABLE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		CH_OFF = 2'd0,
		CH_PENDING = 2'd1,
		CH_RUNNING = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		TACT_NONE = 2'd0,
		TACT_ENABLE = 2'd1,
		TACT_DISABLE = 2'd2
	} tact_t;

	typedef struct packed {
		status_t status;
		logic [CNT_BITS-1:0] end_cmp;
		logic [CNT_BITS-1:0] queued;
		logic [US_BITS-1:0] dwell_len;
		logic [US_BITS-1:0] began_at;
		logic dec_end;
		logic has_q;
	} chan_entry_t;

	typedef struct packed {
		logic [1:0] pad;
		logic [CNT_BITS-1:0] end_count;
		logic [US_BITS-1:0] now_us;
		logic [CNT_BITS-1:0] now_count;
		logic [US_BITS-1:0] length_us;
		logic [US_BITS-1:0] delay_us;
		logic [CH_BITS-1:0] channel;
		logic [2:0] cmd;
	} in_item_t;

	typedef struct packed {
		logic pad;
		logic [15:0] spark_count_out;
		logic [15:0] smoothed_dwell_out;
		logic [1:0] chan_status;
		logic [1:0] timer_action;
		logic [15:0] compare_value;
		logic compare_load;
		logic coil_off;
		logic coil_on;
	} out_item_t;

	function automatic logic [US_BITS-1:0] to_ticks(
		input logic [US_BITS-1:0] us,
		input logic [TS_W-1:0] sh
	);
		return us >> sh;
	endfunction

endpackage

// ===== src/ignition_channel_scheduler_unit.sv =====
// channel   | dir | handshake            | payload
// apb       | in  | psel/penable/pready  | tick_shift @0x0, max_period_us @0x4
// s (items) | in  | s_tvalid/s_tready    | s_tdata: command, channel, times, counts
// m (items) | out | m_tvalid/m_tready    | m_tdata: coil pulses, compare, status
//
// Each item reads its channel entry, then modifies the entry and writes it back.
// A fire on a running channel also passes the dwell smoothing unit, via ST_FILT to ST_EMIT.
// A result waiting on m_tready holds the output register; the next item is taken
// meanwhile and parks until the register frees.
// Reset marks every channel entry invalid; an invalid entry reads as all zero.
module ignition_channel_scheduler_unit #(
	parameter int CHANNELS = ics_pkg::CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ics_pkg::APB_AW-1:0]  paddr,
	input  logic [ics_pkg::APB_DW-1:0]  pwdata,
	output logic [ics_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// cmd, channel, delay_us, length_us, now_count, now_us, end_count
	input  logic [ics_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// coil_on, coil_off, compare_load, compare_value, timer_action,
	// chan_status, smoothed_dwell_out, spark_count_out
	output logic [ics_pkg::OUT_W-1:0]   m_tdata
);
	import ics_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FILT,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [TS_W-1:0] ts_q;
	logic [MAXP_W-1:0] maxp_q;
	logic cfg_wr;

	in_item_t s_item;
	in_item_t in_q;
	logic in_range;
	logic in_range_q;
	logic accept;

	chan_entry_t cur;
	chan_entry_t nxt;
	logic mem_wr_en;

	logic [US_BITS-1:0] t_delay;
	logic [US_BITS-1:0] t_len;
	logic [US_BITS-1:0] t_dwell;
	logic [US_BITS-1:0] t_clamp;
	logic [MAXP_W-1:0] maxp_m1;
	logic [CNT_BITS-1:0] start_cnt;
	logic [US_BITS-1:0] meas;
	logic filt_start;
	logic spark_inc;
	logic [15:0] spark_q;
	logic [15:0] spark_nx;
	logic [15:0] smoothed;

	out_item_t res;
	out_item_t res_q;
	out_item_t out_q;
	out_item_t out_nx;
	logic out_free;
	logic out_load;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= TS_RST;
			maxp_q <= MAXP_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_TICK_SHIFT: ts_q <= pwdata[TS_W-1:0];
				REG_MAX_PERIOD: maxp_q <= pwdata[MAXP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TICK_SHIFT: prdata = APB_DW'(ts_q);
			REG_MAX_PERIOD: prdata = APB_DW'(maxp_q);
			default: prdata = '0;
		endcase
	end

	assign s_item = in_item_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign in_range = (32'(s_item.channel) < 32'(CHANNELS));

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= s_item;
		end
		if (state_q == ST_EXEC) begin
			res_q <= res;
		end
	end

	ics_chan_mem #(
		.CHANNELS(CHANNELS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept && in_range),
		.rd_addr(s_item.channel[AW-1:0]),
		.rd_data(cur),
		.wr_en(mem_wr_en),
		.wr_addr(in_q.channel[AW-1:0]),
		.wr_data(nxt)
	);

	ics_dwell_filter u_filt (
		.clk(clk),
		.arst_n(arst_n),
		.start(filt_start),
		.meas(meas),
		.smoothed(smoothed)
	);

	assign t_delay = to_ticks(in_q.delay_us, ts_q);
	assign t_len = to_ticks(in_q.length_us, ts_q);
	assign t_dwell = to_ticks(cur.dwell_len, ts_q);
	assign maxp_m1 = maxp_q - MAXP_W'(1);
	assign t_clamp = to_ticks(US_BITS'(maxp_m1), ts_q);
	assign meas = in_q.now_us - cur.began_at;

	always_comb begin
		if (in_q.delay_us > US_BITS'(maxp_q)) begin
			start_cnt = in_q.now_count + t_clamp[CNT_BITS-1:0];
		end else begin
			start_cnt = in_q.now_count + t_delay[CNT_BITS-1:0];
		end
	end

	always_comb begin
		nxt = cur;
		res = '0;
		spark_inc = 1'b0;
		filt_start = 1'b0;
		if (in_range_q) begin
			case (cmd_t'(in_q.cmd))
				CMD_SET: begin
					if (cur.status == CH_RUNNING) begin
						nxt.queued = in_q.now_count + t_delay[CNT_BITS-1:0];
						nxt.has_q = 1'b1;
					end else begin
						nxt.dwell_len = in_q.length_us;
						if (!cur.dec_end) begin
							nxt.end_cmp = start_cnt + t_len[CNT_BITS-1:0];
						end
						res.compare_load = 1'b1;
						res.compare_value = start_cnt;
						nxt.status = CH_PENDING;
						res.timer_action = TACT_ENABLE;
					end
				end
				CMD_REFRESH: begin
					if (cur.status == CH_RUNNING && in_q.delay_us < cur.dwell_len) begin
						nxt.end_cmp = in_q.now_count + t_delay[CNT_BITS-1:0];
						res.compare_load = 1'b1;
						res.compare_value = nxt.end_cmp;
					end
				end
				CMD_DEC_END: begin
					nxt.end_cmp = in_q.end_count;
					nxt.dec_end = 1'b1;
				end
				CMD_FIRE: begin
					if (cur.status == CH_PENDING) begin
						res.coil_on = 1'b1;
						nxt.status = CH_RUNNING;
						nxt.began_at = in_q.now_us;
						res.compare_load = 1'b1;
						res.compare_value = cur.dec_end ? cur.end_cmp
							: in_q.now_count + t_dwell[CNT_BITS-1:0];
					end else if (cur.status == CH_RUNNING) begin
						res.coil_off = 1'b1;
						nxt.dec_end = 1'b0;
						spark_inc = 1'b1;
						filt_start = (state_q == ST_EXEC);
						if (cur.has_q) begin
							res.compare_load = 1'b1;
							res.compare_value = cur.queued;
							nxt.status = CH_PENDING;
							nxt.has_q = 1'b0;
						end else begin
							nxt.status = CH_OFF;
							res.timer_action = TACT_DISABLE;
						end
					end else begin
						res.timer_action = TACT_DISABLE;
					end
				end
				CMD_DISABLE: begin
					if (cur.status == CH_PENDING) begin
						nxt.status = CH_OFF;
					end
				end
				default: ;
			endcase
			res.chan_status = nxt.status;
		end
	end

	assign mem_wr_en = (state_q == ST_EXEC) && in_range_q;
	assign spark_nx = spark_q + 16'(spark_inc);
	assign out_free = !out_q.pad && (!m_tvalid || m_tready);
	assign out_load = out_free
		&& ((state_q == ST_EXEC && !filt_start) || state_q == ST_EMIT);

	always_comb begin
		out_nx = (state_q == ST_EMIT) ? res_q : res;
		out_nx.smoothed_dwell_out = smoothed;
		out_nx.spark_count_out = (state_q == ST_EMIT) ? spark_q : spark_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_range_q <= 1'b0;
			spark_q <= '0;
			m_tvalid <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_load) begin
				out_q <= out_nx;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						in_range_q <= in_range;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					spark_q <= spark_nx;
					if (filt_start) begin
						state_q <= ST_FILT;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_FILT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata = OUT_W'(out_q);

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("item accepted without channel read");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> $past(state_q) == ST_IDLE)
		else $error("channel write without preceding read");

	assert property (@(posedge clk) disable iff (!arst_n)
		filt_start |=> state_q == ST_FILT)
		else $error("smoothing start lost");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(out_q.coil_on && out_q.coil_off))
		else $error("coil on and off in one item");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !out_q.compare_load) |-> out_q.compare_value == '0)
		else $error("compare value without load");

endmodule

// ===== src/ics_chan_mem.sv =====
module ics_chan_mem #(
	parameter int CHANNELS = ics_pkg::CHANNELS_DEF,
	parameter int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output ics_pkg::chan_entry_t rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  ics_pkg::chan_entry_t wr_data
);
	import ics_pkg::*;

	chan_entry_t mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;
	chan_entry_t rd_data_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== src/ics_dwell_filter.sv =====
module ics_dwell_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] meas,
	output logic [15:0] smoothed
);
	import ics_pkg::*;

	logic [US_BITS-1:0] meas_s1;
	logic go_s1;
	logic [15:0] smoothed_q;
	logic [SM_W-1:0] acc;

	always_comb begin
		acc = SM_W'(meas_s1) * SM_W'(ONE_MINUS_ALPHA)
			+ SM_W'(smoothed_q) * SM_W'(ALPHA);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			meas_s1 <= meas;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			smoothed_q <= '0;
		end else begin
			go_s1 <= start;
			if (go_s1) begin
				smoothed_q <= (|acc[SM_W-1:24]) ? 16'hFFFF : acc[23:8];
			end
		end
	end

	assign smoothed = smoothed_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import ics_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 76;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// cmd, channel, delay_us, length_us, now_count, now_us, end_count
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// coil_on, coil_off, compare_load, compare_value, timer_action,
	// chan_status, smoothed_dwell_out, spark_count_out
	logic [OUT_W-1:0] m_tdata;

	ignition_channel_scheduler_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// scheduler shadow state
	logic [TS_W-1:0] cfg_shift = TS_RST;
	logic [MAXP_W-1:0] cfg_maxp = MAXP_RST;
	status_t chan_st[8];
	logic [CNT_BITS-1:0] start_cmp[8];
	logic [CNT_BITS-1:0] end_cmp[8];
	logic [CNT_BITS-1:0] queued_start[8];
	logic [US_BITS-1:0] dwell_len[8];
	logic [US_BITS-1:0] began_at[8];
	logic dec_end[8];
	logic has_queued[8];
	logic [15:0] smooth_dwell = '0;
	logic [15:0] spark_total = '0;
	logic [31:0] us_clock = '0;

	in_item_t cmd_item_q[$];
	out_item_t coil_result_q[$];
	int err_cnt = 0;
	int burst_left = 4;
	int gap_left = 0;
	int stall_mode = 0;
	int ready_phase = 0;
	int idle_cycles = 0;

	initial begin
		for (int i = 0; i < 8; i++) begin
			chan_st[i] = CH_OFF;
			start_cmp[i] = '0;
			end_cmp[i] = '0;
			queued_start[i] = '0;
			dwell_len[i] = '0;
			began_at[i] = '0;
			dec_end[i] = 1'b0;
			has_queued[i] = 1'b0;
		end
	end

	function automatic logic [31:0] us_to_ticks(input logic [31:0] us);
		return us >> cfg_shift;
	endfunction

	function automatic out_item_t schedule_step(input in_item_t it);
		out_item_t res;
		logic [2:0] ch;
		logic [31:0] t;
		logic [63:0] meas;
		logic [63:0] sm;
		res = '0;
		ch = it.channel;
		case (it.cmd)
			CMD_SET: begin
				if (chan_st[ch] == CH_RUNNING) begin
					queued_start[ch] = it.now_count + CNT_BITS'(us_to_ticks(it.delay_us));
					has_queued[ch] = 1'b1;
				end else begin
					dwell_len[ch] = it.length_us;
					if (it.delay_us > {12'd0, cfg_maxp})
						t = us_to_ticks({12'd0, cfg_maxp - 20'd1});
					else
						t = us_to_ticks(it.delay_us);
					start_cmp[ch] = it.now_count + t[CNT_BITS-1:0];
					if (!dec_end[ch])
						end_cmp[ch] = start_cmp[ch] + CNT_BITS'(us_to_ticks(it.length_us));
					res.compare_load = 1'b1;
					res.compare_value = start_cmp[ch];
					chan_st[ch] = CH_PENDING;
					res.timer_action = TACT_ENABLE;
				end
			end
			CMD_REFRESH: begin
				if (chan_st[ch] == CH_RUNNING && it.delay_us < dwell_len[ch]) begin
					end_cmp[ch] = it.now_count + CNT_BITS'(us_to_ticks(it.delay_us));
					res.compare_load = 1'b1;
					res.compare_value = end_cmp[ch];
				end
			end
			CMD_DEC_END: begin
				end_cmp[ch] = it.end_count;
				dec_end[ch] = 1'b1;
			end
			CMD_FIRE: begin
				if (chan_st[ch] == CH_PENDING) begin
					res.coil_on = 1'b1;
					chan_st[ch] = CH_RUNNING;
					began_at[ch] = it.now_us;
					res.compare_load = 1'b1;
					if (dec_end[ch])
						res.compare_value = end_cmp[ch];
					else
						res.compare_value = it.now_count +
							CNT_BITS'(us_to_ticks(dwell_len[ch]));
				end else if (chan_st[ch] == CH_RUNNING) begin
					meas = {32'd0, it.now_us - began_at[ch]};
					res.coil_off = 1'b1;
					dec_end[ch] = 1'b0;
					spark_total = spark_total + 16'd1;
					sm = (meas * 64'(ONE_MINUS_ALPHA) + {48'd0, smooth_dwell} * 64'(ALPHA))
						>> 8;
					smooth_dwell = (sm > 64'hFFFF) ? 16'hFFFF : sm[15:0];
					if (has_queued[ch]) begin
						res.compare_load = 1'b1;
						res.compare_value = queued_start[ch];
						chan_st[ch] = CH_PENDING;
						has_queued[ch] = 1'b0;
					end else begin
						chan_st[ch] = CH_OFF;
						res.timer_action = TACT_DISABLE;
					end
				end else begin
					res.timer_action = TACT_DISABLE;
				end
			end
			CMD_DISABLE: begin
				if (chan_st[ch] == CH_PENDING)
					chan_st[ch] = CH_OFF;
			end
			default: begin
			end
		endcase
		res.chan_status = chan_st[ch];
		res.smoothed_dwell_out = smooth_dwell;
		res.spark_count_out = spark_total;
		return res;
	endfunction

	function automatic in_item_t mk(input logic [2:0] op, input logic [2:0] ch,
		input logic [31:0] dly, input logic [31:0] len, input logic [15:0] ncnt,
		input logic [31:0] nus, input logic [15:0] ecnt);
		in_item_t it;
		it = '0;
		it.cmd = op;
		it.channel = ch;
		it.delay_us = dly;
		it.length_us = len;
		it.now_count = ncnt;
		it.now_us = nus;
		it.end_count = ecnt;
		return it;
	endfunction

	function automatic in_item_t random_item(input int n_ch);
		int r;
		logic [2:0] op;
		logic [31:0] dly;
		logic [31:0] len;
		logic [31:0] nus;
		r = $urandom_range(99);
		if (r < 25)
			op = CMD_SET;
		else if (r < 60)
			op = CMD_FIRE;
		else if (r < 72)
			op = CMD_REFRESH;
		else if (r < 82)
			op = CMD_DEC_END;
		else if (r < 93)
			op = CMD_DISABLE;
		else
			op = 3'(CMD_DISABLE) + 3'($urandom_range(3, 1));
		case ($urandom_range(3))
			0: dly = $urandom;
			1: dly = {12'd0, cfg_maxp} + $urandom_range(2) - 1;
			default: dly = $urandom_range(3000);
		endcase
		len = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3000);
		us_clock = us_clock + $urandom_range(4000);
		nus = ($urandom_range(7) == 0) ? $urandom : us_clock;
		return mk(op, 3'($urandom_range(n_ch - 1)), dly, len, 16'($urandom), nus,
			16'($urandom));
	endfunction

	function automatic string fmt(input out_item_t r);
		return $sformatf("on=%0d off=%0d load=%0d cval=%h tact=%0d st=%0d sm=%h cnt=%h",
			r.coil_on, r.coil_off, r.compare_load, r.compare_value, r.timer_action,
			r.chan_status, r.smoothed_dwell_out, r.spark_count_out);
	endfunction

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[2] == REG_MAX_PERIOD)
			cfg_maxp = data[MAXP_W-1:0];
		else
			cfg_shift = data[TS_W-1:0];
	endtask

	task automatic drain();
		while (cmd_item_q.size() != 0 || coil_result_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// item driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid) begin
				coil_result_q.push_back(schedule_step(cmd_item_q.pop_front()));
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (cmd_item_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= cmd_item_q[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = out_item_t'(m_tdata);
				if (coil_result_q.size() == 0) begin
					if (err_cnt < 10)
						$display("%0t: unexpected result %s", $realtime, fmt(got));
					err_cnt++;
				end else begin
					want = coil_result_q.pop_front();
					if (got.coil_on !== want.coil_on || got.coil_off !== want.coil_off ||
						got.compare_load !== want.compare_load ||
						got.compare_value !== want.compare_value ||
						got.timer_action !== want.timer_action ||
						got.chan_status !== want.chan_status ||
						got.smoothed_dwell_out !== want.smoothed_dwell_out ||
						got.spark_count_out !== want.spark_count_out) begin
						if (err_cnt < 10)
							$display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
								fmt(want), fmt(got));
						err_cnt++;
					end
				end
			end
			ready_phase++;
			if (ready_phase % 97 == 0)
				stall_mode = $urandom_range(3);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= (ready_phase % 3 == 0);
				2: m_tready <= 1'($urandom_range(1));
				default: m_tready <= (ready_phase % 16 >= 8);
			endcase
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else if (cmd_item_q.size() != 0 || coil_result_q.size() != 0)
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int unsigned shift_set[PHASES];
		int unsigned maxp_set[PHASES];
		int n_ch;
		shift_set = '{0, 4, 3, 1, 2};
		maxp_set = '{1, 1048575, 0, 1000, 262140};
		stall_mode = $urandom_range(3);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		@(negedge clk);
		cmd_item_q.push_back(mk(CMD_FIRE, 3'd1, 0, 0, 0, 0, 0));
		cmd_item_q.push_back(mk(CMD_SET, 3'd0, 0, 0, 0, 0, 0));
		cmd_item_q.push_back(mk(CMD_FIRE, 3'd0, 0, 0, 0, 0, 0));
		cmd_item_q.push_back(mk(CMD_REFRESH, 3'd0, 0, 0, 16'd10, 0, 0));
		cmd_item_q.push_back(mk(CMD_SET, 3'd0, '1, '1, '1, '1, '1));
		cmd_item_q.push_back(mk(CMD_FIRE, 3'd0, 0, 0, '1, '1, 0));
		cmd_item_q.push_back(mk(CMD_DISABLE, 3'd0, 0, 0, 0, 0, 0));
		cmd_item_q.push_back(mk(CMD_DEC_END, 3'd7, 0, 0, 0, 0, '1));
		cmd_item_q.push_back(mk(CMD_SET, 3'd7, '1, '1, '1, 0, 0));
		cmd_item_q.push_back(mk(CMD_FIRE, 3'd7, 0, 0, 16'd77, 32'd100, 0));
		cmd_item_q.push_back(mk(CMD_REFRESH, 3'd7, 32'd5, 0, 16'h1234, 0, 0));
		cmd_item_q.push_back(mk(CMD_REFRESH, 3'd7, '1, 0, 16'h4321, 0, 0));
		cmd_item_q.push_back(mk(CMD_FIRE, 3'd7, 0, 0, 0, 32'd7100, 0));
		cmd_item_q.push_back(mk(CMD_SET, 3'd3, 32'd262140, 32'd400, 16'hFFF0, 0, 0));
		cmd_item_q.push_back(mk(CMD_SET, 3'd4, 32'd262141, 32'd400, 16'd3, 0, 0));
		cmd_item_q.push_back(mk(CMD_DISABLE, 3'd4, 0, 0, 0, 0, 0));
		cmd_item_q.push_back(mk(CMD_DISABLE, 3'd5, 0, 0, 0, 0, 0));
		cmd_item_q.push_back(mk(3'(CMD_DISABLE) + 3'd1, 3'd2, '1, '1, '1, '1, '1));
		cmd_item_q.push_back(mk(3'(CMD_DISABLE) + 3'd2, 3'd6, '1, '1, '1, '1, '1));
		cmd_item_q.push_back(mk(3'(CMD_DISABLE) + 3'd3, 3'd3, '1, '1, '1, '1, '1));
		cmd_item_q.push_back(mk(CMD_FIRE, 3'd3, 0, 0, 16'd50, 32'd5000, 0));
		cmd_item_q.push_back(mk(CMD_FIRE, 3'd3, 0, 0, 16'd60, 32'd5600, 0));
		cmd_item_q.push_back(mk(CMD_REFRESH, 3'd2, 0, 0, 0, 0, 0));
		drain();
		for (int p = 0; p < PHASES; p++) begin
			apb_write({REG_TICK_SHIFT, 2'b00}, shift_set[p]);
			apb_write({REG_MAX_PERIOD, 2'b00}, maxp_set[p]);
			n_ch = (p % 2 == 1) ? 2 : 8;
			@(negedge clk);
			for (int i = 0; i < PHASE_ITEMS; i++)
				cmd_item_q.push_back(random_item(n_ch));
			drain();
		end
		if (err_cnt == 0 && coil_result_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ics_pkg.sv
src/ics_chan_mem.sv
src/ics_dwell_filter.sv
src/ignition_channel_scheduler_unit.sv
bench/tb_top.sv
